[hdl/ndef_pkg.sv]
// Shared types and constants for the NDEF text record parser.
// No dependencies; every other file in hdl/ imports this package.
package ndef_pkg;

    localparam logic [7:0] TLV_NDEF_TAG   = 8'h03;
    localparam logic [7:0] TLV_LONG_LEN   = 8'hFF;
    localparam int unsigned HDR_ID_BIT    = 3;
    localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
    localparam logic [7:0] TYPE_TEXT      = 8'h54;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_TLV    = 3'd1,
        ST_LONG_LEN  = 3'd2,
        ST_NOT_TEXT  = 3'd3,
        ST_BAD_TNF   = 3'd4,
        ST_BAD_LEN   = 3'd5
    } t_status;

    typedef struct packed {
        logic       start_of_buffer;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic       has_byte;
        t_status    status;
        logic [7:0] text_length;
        logic       last;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
    } t_result;

endpackage

[hdl/ndef_in_reg.sv]
// Input register stage: captures one input transfer and holds it until the
// parser consumes it. Depends on ndef_pkg.
module ndef_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ndef_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output ndef_pkg::t_in_item o_item
);
    import ndef_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // refill in the same cycle the held item is consumed
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[hdl/ndef_parse.sv]
// Record parser: header state and the per-byte field update that decides
// whether a byte yields a result. Depends on ndef_pkg.
module ndef_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  ndef_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output ndef_pkg::t_result  o_res
);
    import ndef_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_TLVLEN, PH_HDR, PH_TYPELEN, PH_PAYLEN, PH_IDLEN,
        PH_TYPE, PH_IDSKIP, PH_LANGLEN, PH_LANGSKIP, PH_TEXT, PH_DONE
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_id_flag, n_id_flag;
    logic [2:0] r_tnf, n_tnf;
    logic [7:0] r_type_len, n_type_len;
    logic [7:0] r_rec_len, n_rec_len;
    logic [7:0] r_skip_len, n_skip_len;
    logic [7:0] r_first_type, n_first_type;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_out_index, n_out_index;

    logic [7:0] b;
    logic [7:0] rem_dec;
    logic [7:0] skip_dec;
    logic [7:0] first_type;
    logic [7:0] text_len;

    assign b        = i_item.data_byte;
    assign rem_dec  = r_remaining - 8'd1;
    assign skip_dec = r_skip_len - 8'd1;
    assign first_type = (r_remaining == r_type_len) ? b : r_first_type;
    assign text_len = r_rec_len - b - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_id_flag    = r_id_flag;
        n_tnf        = r_tnf;
        n_type_len   = r_type_len;
        n_rec_len    = r_rec_len;
        n_skip_len   = r_skip_len;
        n_first_type = r_first_type;
        n_remaining  = r_remaining;
        n_out_index  = r_out_index;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.status = ST_OK;

        if (i_item.start_of_buffer) begin
            // restart: clear the header fields, then check the TLV tag
            n_id_flag    = 1'b0;
            n_tnf        = '0;
            n_type_len   = '0;
            n_rec_len    = '0;
            n_skip_len   = '0;
            n_first_type = '0;
            n_remaining  = '0;
            n_out_index  = '0;
            if (b != TLV_NDEF_TAG) begin
                n_phase      = PH_DONE;
                o_res_valid  = 1'b1;
                o_res.last   = 1'b1;
                o_res.status = ST_NO_TLV;
            end else begin
                n_phase = PH_TLVLEN;
            end
        end else begin
            case (r_phase)
                PH_TLVLEN: begin
                    if (b == TLV_LONG_LEN) begin
                        n_phase      = PH_DONE;
                        o_res_valid  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = ST_LONG_LEN;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
                PH_HDR: begin
                    n_id_flag = b[HDR_ID_BIT];
                    n_tnf     = b[2:0];
                    n_phase   = PH_TYPELEN;
                end
                PH_TYPELEN: begin
                    n_type_len = b;
                    n_phase    = PH_PAYLEN;
                end
                PH_PAYLEN, PH_IDLEN: begin
                    if (r_phase == PH_PAYLEN) begin
                        n_rec_len = b;
                    end else begin
                        n_skip_len = b;
                    end
                    if (r_phase == PH_PAYLEN && r_id_flag) begin
                        n_phase = PH_IDLEN;
                    end else if (r_type_len == 8'd0) begin
                        n_phase      = PH_DONE;
                        o_res_valid  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = ST_NOT_TEXT;
                    end else begin
                        n_remaining = r_type_len;
                        n_phase     = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_first_type = first_type;
                    n_remaining  = rem_dec;
                    if (rem_dec == 8'd0) begin
                        if (first_type != TYPE_TEXT) begin
                            n_phase      = PH_DONE;
                            o_res_valid  = 1'b1;
                            o_res.last   = 1'b1;
                            o_res.status = ST_NOT_TEXT;
                        end else if (r_tnf != TNF_WELL_KNOWN) begin
                            n_phase      = PH_DONE;
                            o_res_valid  = 1'b1;
                            o_res.last   = 1'b1;
                            o_res.status = ST_BAD_TNF;
                        end else if (r_id_flag && r_skip_len != 8'd0) begin
                            n_remaining = r_skip_len;
                            n_phase     = PH_IDSKIP;
                        end else begin
                            n_phase = PH_LANGLEN;
                        end
                    end
                end
                PH_IDSKIP: begin
                    n_remaining = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_LANGLEN;
                    end
                end
                PH_LANGLEN: begin
                    // language field (length byte plus code) must fit the payload
                    if (b >= r_rec_len) begin
                        n_phase      = PH_DONE;
                        o_res_valid  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = ST_BAD_LEN;
                    end else begin
                        n_rec_len  = text_len;
                        n_skip_len = b;
                        if (b != 8'd0) begin
                            n_phase = PH_LANGSKIP;
                        end else begin
                            n_out_index = '0;
                            n_remaining = text_len;
                            if (text_len == 8'd0) begin
                                n_phase     = PH_DONE;
                                o_res_valid = 1'b1;
                                o_res.last  = 1'b1;
                            end else begin
                                n_phase = PH_TEXT;
                            end
                        end
                    end
                end
                PH_LANGSKIP: begin
                    n_skip_len = skip_dec;
                    if (skip_dec == 8'd0) begin
                        n_out_index = '0;
                        n_remaining = r_rec_len;
                        if (r_rec_len == 8'd0) begin
                            n_phase     = PH_DONE;
                            o_res_valid = 1'b1;
                            o_res.last  = 1'b1;
                        end else begin
                            n_phase = PH_TEXT;
                        end
                    end
                end
                PH_TEXT: begin
                    n_out_index        = r_out_index + 8'd1;
                    n_remaining        = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_DONE;
                    end
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = b;
                    o_res.byte_index   = r_out_index;
                    o_res.last         = (r_remaining == 8'd1);
                    o_res.text_length  = r_rec_len;
                    o_res.has_byte     = 1'b1;
                end
                default: begin
                    // idle or done: drop the byte
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_id_flag    <= 1'b0;
            r_tnf        <= '0;
            r_type_len   <= '0;
            r_rec_len    <= '0;
            r_skip_len   <= '0;
            r_first_type <= '0;
            r_remaining  <= '0;
            r_out_index  <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_id_flag    <= n_id_flag;
            r_tnf        <= n_tnf;
            r_type_len   <= n_type_len;
            r_rec_len    <= n_rec_len;
            r_skip_len   <= n_skip_len;
            r_first_type <= n_first_type;
            r_remaining  <= n_remaining;
            r_out_index  <= n_out_index;
        end
    end

endmodule

[hdl/ndef_out_reg.sv]
// Result register: holds one parser result until the downstream transfer.
// Depends on ndef_pkg.
module ndef_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  ndef_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output ndef_pkg::t_result o_res
);
    import ndef_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

[hdl/ndef_text_record_parser.sv]
// NDEF text record parser, top level: input register, parser, result register.
// Depends on ndef_pkg, ndef_in_reg, ndef_parse and ndef_out_reg.
//
// Usage: tag-memory bytes enter on the s_axis channel, one per transfer, with
// s_axis_tuser high on the first byte of a buffer (this restarts parsing).
// Text bytes leave on m_axis with their index and the net text length; a
// malformed buffer gives one result with tlast high and a nonzero status in
// m_axis_tuser. Bytes that produce nothing (headers, skipped ID and language
// bytes, anything before a start or after the final result) are dropped.
// Throughput: one byte per cycle while the result register is free; each byte
// takes a single pass through the header-update logic between the input and
// result registers. Path: the byte waits in the input register, is parsed
// combinationally, and its result is captured in the result register, which
// drives m_axis_tvalid.
// Stall: while a result waits with m_axis_tready low the result register holds,
// the parser stops, and the input register keeps one more byte before
// s_axis_tready drops. With the result register empty, bytes that give no
// result keep flowing.
// Reset (synchronous, active low) empties both registers and returns the
// parser to idle, waiting for a start byte.
module ndef_text_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                        // [23:16] text_length
    output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] has_byte
    output logic        m_axis_tlast
);
    import ndef_pkg::*;

    t_in_item in_item, held_item;
    t_result  res, out_res;
    logic     held_valid;
    logic     out_free;
    logic     step;
    logic     res_valid;

    assign in_item.data_byte       = s_axis_tdata;
    assign in_item.start_of_buffer = s_axis_tuser[0];
    assign step = held_valid && out_free;

    ndef_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (out_free),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    ndef_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ndef_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (held_valid),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_free      (out_free),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {out_res.text_length, out_res.byte_index, out_res.payload_byte};
    assign m_axis_tuser = {out_res.has_byte, out_res.status};
    assign m_axis_tlast = out_res.last;

endmodule
